// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the battery poller.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define MBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MBP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/mbp_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte step for the battery poller.
// No dependencies; every other RTL module but the checker imports this package.
`default_nettype none

package mbp_pkg;

    // Register indexes on the configuration port (byte address = 4 * index)
    localparam logic [2:0] REG_DEVICE_ADDRESS   = 3'd0;
    localparam logic [2:0] REG_FUNCTION_CODE    = 3'd1;
    localparam logic [2:0] REG_VOLTAGE_REGISTER = 3'd2;
    localparam logic [2:0] REG_PERCENT_REGISTER = 3'd3;
    localparam logic [2:0] REG_CURRENT_REGISTER = 3'd4;

    localparam int unsigned PADDR_W = 5;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_DEVICE_ADDRESS   = 8'h01;
    localparam logic [7:0] RST_FUNCTION_CODE    = 8'h03;
    localparam logic [7:0] RST_VOLTAGE_REGISTER = 8'h00;
    localparam logic [7:0] RST_PERCENT_REGISTER = 8'h01;
    localparam logic [7:0] RST_CURRENT_REGISTER = 8'h02;

    // Input kinds
    localparam logic ACTION_TICK     = 1'b0;
    localparam logic ACTION_RESPONSE = 1'b1;

    // Round-robin register selector
    localparam logic [1:0] SEL_VOLTAGE = 2'd0;
    localparam logic [1:0] SEL_PERCENT = 2'd1;
    localparam logic [1:0] SEL_CURRENT = 2'd2;

    // Response header match
    localparam logic [7:0] RESP_ADDR_MATCH = 8'h01;
    localparam logic [7:0] RESP_FUNC_MATCH = 8'h03;

    // Request frame byte positions
    localparam logic [2:0] BYTE_DEVICE   = 3'd0;
    localparam logic [2:0] BYTE_FUNCTION = 3'd1;
    localparam logic [2:0] BYTE_REG_HI   = 3'd2;
    localparam logic [2:0] BYTE_REG_LO   = 3'd3;
    localparam logic [2:0] BYTE_CNT_HI   = 3'd4;
    localparam logic [2:0] BYTE_CNT_LO   = 3'd5;
    localparam logic [2:0] BYTE_CRC_LO   = 3'd6;
    localparam logic [2:0] BYTE_CRC_HI   = 3'd7;

    localparam logic [7:0] REQ_ZERO      = 8'h00;
    localparam logic [7:0] REQ_COUNT_ONE = 8'h01;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] function_code;
        logic [7:0] voltage_register;
        logic [7:0] percent_register;
        logic [7:0] current_register;
    } cfg_t;

    typedef struct packed {
        logic [15:0] voltage;
        logic [15:0] percent;
        logic [15:0] current;
    } values_t;

    // Job handed from the core to the transmit stage
    typedef struct packed {
        logic       valid;
        logic       frame;     // 1: eight-byte request, 0: single status beat
        logic [7:0] reg_addr;  // register address for request byte three
    } job_req_t;

    // One byte of reflected CRC-16, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mbp_cfg_regs.sv =====
// APB-style configuration register file of the battery poller.
// Depends on mbp_pkg (register indexes, reset values, cfg_t).
`default_nettype none

module mbp_cfg_regs (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [mbp_pkg::PADDR_W-1:0]   paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output mbp_pkg::cfg_t                cfg
);
    import mbp_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign reg_idx = paddr[4:2];
    // pready is tied high at the top level
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address   <= RST_DEVICE_ADDRESS;
            cfg_reg.function_code    <= RST_FUNCTION_CODE;
            cfg_reg.voltage_register <= RST_VOLTAGE_REGISTER;
            cfg_reg.percent_register <= RST_PERCENT_REGISTER;
            cfg_reg.current_register <= RST_CURRENT_REGISTER;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DEVICE_ADDRESS:   cfg_reg.device_address   <= pwdata[7:0];
                REG_FUNCTION_CODE:    cfg_reg.function_code    <= pwdata[7:0];
                REG_VOLTAGE_REGISTER: cfg_reg.voltage_register <= pwdata[7:0];
                REG_PERCENT_REGISTER: cfg_reg.percent_register <= pwdata[7:0];
                REG_CURRENT_REGISTER: cfg_reg.current_register <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DEVICE_ADDRESS:   prdata = {24'h0, cfg_reg.device_address};
            REG_FUNCTION_CODE:    prdata = {24'h0, cfg_reg.function_code};
            REG_VOLTAGE_REGISTER: prdata = {24'h0, cfg_reg.voltage_register};
            REG_PERCENT_REGISTER: prdata = {24'h0, cfg_reg.percent_register};
            REG_CURRENT_REGISTER: prdata = {24'h0, cfg_reg.current_register};
            default:              prdata = 32'h0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/mbp_core.sv =====
// Input beat register and poller state: round robin, ready flag, stored values.
// Depends on mbp_pkg (cfg_t, values_t, job_req_t, codes).
`default_nettype none

module mbp_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire [31:0]          s_tdata,   // resp_address, resp_function,
                                           // resp_data_high, resp_data_low
    input  wire [0:0]           s_tuser,   // action
    input  mbp_pkg::cfg_t       cfg,
    input  wire                 tx_free,
    output mbp_pkg::job_req_t   job_req,
    output mbp_pkg::values_t    values
);
    import mbp_pkg::*;

    logic        in_valid_reg;
    logic        in_action_reg;
    logic [31:0] in_data_reg;

    logic [1:0]  query_select_reg, query_select_next;
    logic [1:0]  pending_reg,      pending_next;
    logic        poll_ready_reg,   poll_ready_next;
    values_t     values_reg,       values_next;

    logic        consume;
    logic        resp_match;
    logic        send_req;
    logic [7:0]  sel_reg_addr;
    logic [15:0] resp_word;

    assign consume  = in_valid_reg && tx_free;
    assign s_tready = !in_valid_reg || consume;

    assign resp_match = (in_data_reg[7:0] == RESP_ADDR_MATCH) &&
                        (in_data_reg[15:8] == RESP_FUNC_MATCH);
    assign resp_word  = {in_data_reg[23:16], in_data_reg[31:24]};
    assign send_req   = (in_action_reg == ACTION_TICK) && poll_ready_reg;

    always_comb
    begin
        case (query_select_reg)
            SEL_PERCENT: sel_reg_addr = cfg.percent_register;
            SEL_CURRENT: sel_reg_addr = cfg.current_register;
            default:     sel_reg_addr = cfg.voltage_register;
        endcase
    end

    always_comb
    begin
        query_select_next = query_select_reg;
        pending_next      = pending_reg;
        poll_ready_next   = poll_ready_reg;
        values_next       = values_reg;
        if (consume)
        begin
            if (in_action_reg == ACTION_TICK)
            begin
                if (poll_ready_reg)
                begin
                    poll_ready_next   = 1'b0;
                    pending_next      = query_select_reg;
                    query_select_next = (query_select_reg >= SEL_CURRENT) ?
                                        SEL_VOLTAGE : query_select_reg + 2'd1;
                end
            end
            else if (resp_match)
            begin
                case (pending_reg)
                    SEL_VOLTAGE: values_next.voltage = resp_word;
                    SEL_PERCENT: values_next.percent = resp_word;
                    SEL_CURRENT: values_next.current = resp_word;
                    default: ;
                endcase
                poll_ready_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            query_select_reg <= SEL_VOLTAGE;
            pending_reg      <= SEL_VOLTAGE;
            poll_ready_reg   <= 1'b1;
            values_reg       <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            query_select_reg <= query_select_next;
            pending_reg      <= pending_next;
            poll_ready_reg   <= poll_ready_next;
            values_reg       <= values_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_action_reg <= s_tuser[0];
            in_data_reg   <= s_tdata;
        end
    end

    assign job_req.valid    = consume;
    assign job_req.frame    = send_req;
    assign job_req.reg_addr = sel_reg_addr;
    assign values           = values_reg;

endmodule

`default_nettype wire

// ===== rtl/mbp_tx.sv =====
// Transmit stage: walks a job beat by beat, folds the CRC one byte per beat,
// and holds the result beat in the output register. Depends on mbp_pkg.
`default_nettype none

module mbp_tx (
    input  wire                 clk,
    input  wire                 rst_n,
    input  mbp_pkg::job_req_t   job_req,
    input  mbp_pkg::cfg_t       cfg,
    input  mbp_pkg::values_t    values,
    output logic                tx_free,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [55:0]         m_tdata,   // tx_byte, voltage, percent, current
    output logic [0:0]          m_tuser,   // frame_valid
    output logic                m_tlast
);
    import mbp_pkg::*;

    logic        job_valid_reg;
    logic        job_frame_reg;
    logic [7:0]  job_reg_addr_reg;
    logic [2:0]  idx_reg;
    logic [15:0] crc_reg;

    logic        out_valid_reg;
    logic [55:0] out_data_reg;
    logic        out_flag_reg;
    logic        out_last_reg;

    logic        load;
    logic        job_last;
    logic [7:0]  frame_byte;
    logic [7:0]  beat_byte;
    logic [15:0] crc_seed;

    assign load     = !out_valid_reg || m_tready;
    assign job_last = !job_frame_reg || (idx_reg == BYTE_CRC_HI);
    assign tx_free  = !job_valid_reg || (load && job_last);

    always_comb
    begin
        case (idx_reg)
            BYTE_DEVICE:   frame_byte = cfg.device_address;
            BYTE_FUNCTION: frame_byte = cfg.function_code;
            BYTE_REG_HI:   frame_byte = REQ_ZERO;
            BYTE_REG_LO:   frame_byte = job_reg_addr_reg;
            BYTE_CNT_HI:   frame_byte = REQ_ZERO;
            BYTE_CNT_LO:   frame_byte = REQ_COUNT_ONE;
            BYTE_CRC_LO:   frame_byte = crc_reg[7:0];
            BYTE_CRC_HI:   frame_byte = crc_reg[15:8];
            default:       frame_byte = REQ_ZERO;
        endcase
    end

    assign beat_byte = job_frame_reg ? frame_byte : REQ_ZERO;
    assign crc_seed  = (idx_reg == BYTE_DEVICE) ? CRC_INIT : crc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_req.valid)
                job_valid_reg <= 1'b1;
            else if (load && job_valid_reg && job_last)
                job_valid_reg <= 1'b0;
            if (load)
                out_valid_reg <= job_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_req.valid)
        begin
            job_frame_reg    <= job_req.frame;
            job_reg_addr_reg <= job_req.reg_addr;
            idx_reg          <= BYTE_DEVICE;
        end
        else if (load && job_valid_reg && !job_last)
            idx_reg <= idx_reg + 3'd1;

        // CRC covers the six header bytes as they go out
        if (load && job_valid_reg && job_frame_reg && (idx_reg < BYTE_CRC_LO))
            crc_reg <= crc_byte(crc_seed, frame_byte);

        if (load && job_valid_reg)
        begin
            out_data_reg <= {values.current, values.percent, values.voltage, beat_byte};
            out_flag_reg <= job_frame_reg;
            out_last_reg <= job_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/modbus_battery_register_poller_unit.sv =====
// An input beat moves via the input and job registers into the output register.
// Throughput: a poll tick that sends a request gives eight output beats, one per cycle
// while m_tready holds high, set by one request byte per beat; any other item gives one beat.
// The next input beat is taken while the current job still drains.
// Reset (rst_n low, async): config to defaults, voltage register queried next,
// ready flag set, stored values zero, both stream sides empty.
`default_nettype none

module modbus_battery_register_poller_unit (
    input  wire         clk,
    input  wire         rst_n,
    // Configuration port, registers at byte address 4*index
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [4:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [31:0]  s_tdata,   // [7:0] resp_address, [15:8] resp_function,
                                   // [23:16] resp_data_high, [31:24] resp_data_low
    input  wire [0:0]   s_tuser,   // [0] action: 0 poll tick, 1 response header
    // Output stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // [7:0] tx_byte, [23:8] voltage,
                                   // [39:24] percent, [55:40] current
    output logic [0:0]  m_tuser,   // [0] frame_valid
    output logic        m_tlast    // last beat caused by this input item
);
    import mbp_pkg::*;

    cfg_t     cfg;
    values_t  values;
    job_req_t job_req;
    logic     tx_free;

    // Writes complete in the access cycle; no wait states.
    assign pready = 1'b1;

    // Register file: device address, function code and the three register numbers.
    mbp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Core: registers the input beat, then decides in one pass whether a tick
    // sends a request (only when the previous one was answered) and stores the
    // data word of a matching response into the value last queried. The item
    // is consumed only when the transmit stage can take its job.
    mbp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg),
        .tx_free  (tx_free),
        .job_req  (job_req),
        .values   (values)
    );

    // Transmit: a request job walks the eight frame bytes; the CRC register
    // absorbs bytes zero to five as they are loaded, so the two CRC bytes are
    // ready when their turn comes. Every beat carries the stored values.
    mbp_tx u_tx (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_req  (job_req),
        .cfg      (cfg),
        .values   (values),
        .tx_free  (tx_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/mbp_checker.sv =====
// Port-level checks on the battery poller output stream, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mbp_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [55:0] m_tdata,
    input wire [0:0]  m_tuser,
    input wire        m_tlast
);

    // A stalled beat keeps its content
    `MBP_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)), "output beat changed while stalled")

    // A status beat is a lone beat with a zero byte
    `MBP_ASSERT(a_status_beat, (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata[7:0] == 8'h00)), "status beat not last or byte not zero")

    // Request bytes follow each other without gaps
    `MBP_ASSERT(a_frame_gapless, (m_tvalid && m_tready && m_tuser[0] && !m_tlast) |=> (m_tvalid && m_tuser[0]), "gap inside a request frame")

    // Nothing is offered while reset is held
    `MBP_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !m_tvalid, "output valid during reset")

endmodule

bind modbus_battery_register_poller_unit mbp_checker u_mbp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
